// ===== hw/rtl/cpt_pkg.sv =====
// Shared types, register map and reset constants of the compressor protect timer.
package cpt_pkg;

	localparam int unsigned AddrWidth = 5;
	localparam int unsigned IdxWidth  = 3;

	localparam logic [IdxWidth-1:0] REG_PROTECT_RELOAD = 3'd0;
	localparam logic [IdxWidth-1:0] REG_FIRST_LIMIT    = 3'd1;
	localparam logic [IdxWidth-1:0] REG_SECOND_LIMIT   = 3'd2;
	localparam logic [IdxWidth-1:0] REG_TIME_CAP       = 3'd3;
	localparam logic [IdxWidth-1:0] REG_PRESCALE       = 3'd4;

	localparam logic [15:0] RST_PROTECT_RELOAD = 16'd300;
	localparam logic [15:0] RST_FIRST_LIMIT    = 16'd9000;
	localparam logic [15:0] RST_SECOND_LIMIT   = 16'd11400;
	localparam logic [15:0] RST_TIME_CAP       = 16'd60000;
	localparam logic [7:0]  RST_PRESCALE       = 8'd10;
	localparam logic [15:0] RST_OFF_SECONDS    = 16'd5;
	localparam logic [15:0] RUN_COUNT_MAX      = 16'hFFFF;

	localparam int unsigned InDataWidth  = 24;
	localparam int unsigned OutDataWidth = 72;

	typedef enum logic [1:0] {
		FUNC_TICK          = 2'd0,
		FUNC_LOAD_PROTECT  = 2'd1,
		FUNC_CLEAR_RUN     = 2'd2
	} func_t;

	typedef struct packed {
		logic [15:0] protect_off_reload;
		logic [15:0] first_on_limit;
		logic [15:0] second_on_limit;
		logic [15:0] time_cap;
		logic [7:0]  prescale_reload;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        cold_request;
		logic        ice_request;
		logic        forced_mode;
		logic        forced_on;
		logic [15:0] protect_value;
	} item_t;

	typedef struct packed {
		logic [15:0] run_count;
		logic        over_second_limit;
		logic        over_first_limit;
		logic        protect_expired;
		logic [15:0] protect_remaining;
		logic [15:0] off_seconds;
		logic [15:0] on_seconds;
		logic        compressor_on;
	} result_t;

endpackage

// ===== hw/rtl/cpt_cfg.sv =====
// Configuration register file behind the APB-style port.
module cpt_cfg
	import cpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	logic                wr_en;
	logic [IdxWidth-1:0] idx;
	cfg_t                cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[AddrWidth-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protect_off_reload <= RST_PROTECT_RELOAD;
			cfg_q.first_on_limit     <= RST_FIRST_LIMIT;
			cfg_q.second_on_limit    <= RST_SECOND_LIMIT;
			cfg_q.time_cap           <= RST_TIME_CAP;
			cfg_q.prescale_reload    <= RST_PRESCALE;
		end else if (wr_en) begin
			case (idx)
				REG_PROTECT_RELOAD: cfg_q.protect_off_reload <= pwdata[15:0];
				REG_FIRST_LIMIT:    cfg_q.first_on_limit     <= pwdata[15:0];
				REG_SECOND_LIMIT:   cfg_q.second_on_limit    <= pwdata[15:0];
				REG_TIME_CAP:       cfg_q.time_cap           <= pwdata[15:0];
				REG_PRESCALE:       cfg_q.prescale_reload    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PROTECT_RELOAD: prdata = {16'd0, cfg_q.protect_off_reload};
			REG_FIRST_LIMIT:    prdata = {16'd0, cfg_q.first_on_limit};
			REG_SECOND_LIMIT:   prdata = {16'd0, cfg_q.second_on_limit};
			REG_TIME_CAP:       prdata = {16'd0, cfg_q.time_cap};
			REG_PRESCALE:       prdata = {24'd0, cfg_q.prescale_reload};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

// ===== hw/rtl/cpt_core.sv =====
// Compressor state registers and the per-word update logic.
module cpt_core
	import cpt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    en,
	input  item_t   item,
	output result_t result
);

	logic        running_q, running_d;
	logic [15:0] on_q, on_d;
	logic [15:0] off_q, off_d;
	logic [15:0] protect_q, protect_d;
	logic [7:0]  prescale_q, prescale_d;
	logic [15:0] run_q, run_d;

	logic        demand;
	logic        start_ok;
	logic [15:0] protect_base;

	always_comb begin
		running_d    = running_q;
		on_d         = on_q;
		off_d        = off_q;
		protect_d    = protect_q;
		prescale_d   = prescale_q;
		run_d        = run_q;
		// Forced on skips the protect check; otherwise a stopped compressor waits
		// for the countdown to reach zero.
		start_ok     = running_q || (protect_q == 16'd0);
		demand       = item.forced_mode ? item.forced_on
		                                : ((item.cold_request | item.ice_request) & start_ok);
		protect_base = running_q ? cfg.protect_off_reload : protect_q;
		case (item.func)
			FUNC_TICK: begin
				if (demand) begin
					running_d = 1'b1;
					off_d     = 16'd0;
					on_d      = (on_q < cfg.time_cap) ? on_q + 16'd1 : on_q;
					protect_d = cfg.protect_off_reload;
					if (prescale_q != 8'd0) begin
						prescale_d = prescale_q - 8'd1;
					end else begin
						prescale_d = cfg.prescale_reload;
						run_d      = (run_q != RUN_COUNT_MAX) ? run_q + 16'd1 : run_q;
					end
				end else begin
					running_d = 1'b0;
					on_d      = 16'd0;
					off_d     = (off_q < cfg.time_cap) ? off_q + 16'd1 : off_q;
					protect_d = (protect_base != 16'd0) ? protect_base - 16'd1 : 16'd0;
				end
			end
			FUNC_LOAD_PROTECT: begin
				protect_d = item.protect_value;
			end
			FUNC_CLEAR_RUN: begin
				prescale_d = cfg.prescale_reload;
				run_d      = 16'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			on_q       <= 16'd0;
			off_q      <= RST_OFF_SECONDS;
			protect_q  <= RST_PROTECT_RELOAD;
			prescale_q <= RST_PRESCALE;
			run_q      <= 16'd0;
		end else if (en) begin
			running_q  <= running_d;
			on_q       <= on_d;
			off_q      <= off_d;
			protect_q  <= protect_d;
			prescale_q <= prescale_d;
			run_q      <= run_d;
		end
	end

	assign result.compressor_on     = running_d;
	assign result.on_seconds        = on_d;
	assign result.off_seconds       = off_d;
	assign result.protect_remaining = protect_d;
	assign result.protect_expired   = running_d | (protect_d == 16'd0);
	assign result.over_first_limit  = on_d > cfg.first_on_limit;
	assign result.over_second_limit = on_d > cfg.second_on_limit;
	assign result.run_count         = run_d;

endmodule

// ===== hw/rtl/compressor_protect_timer_core.sv =====
// Top level of the compressor protect timer: input register, core and result register.
//
//   channel  direction  handshake                  contents
//   s_*      in         s_tvalid / s_tready        command word, func in s_tuser
//   m_*      out        m_tvalid / m_tready        status word after the command
//   apb      in         psel, penable, pwrite      five configuration registers
//
// A word is evaluated against the state registers while it sits in the input
// register and is written to the result register once that register is empty or
// m_tready is high; one word per cycle is sustained while m_tready is high. The
// result register decouples the sides: a stalled m_tready blocks the input only
// once both registers are full.
// Reset restores control, configuration and compressor state at once, no sweep needed.
module compressor_protect_timer_core
	import cpt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// [0] cold_request, [1] ice_request, [2] forced_mode, [3] forced_on,
	// [19:4] protect_value, [23:20] zero
	input  logic [InDataWidth-1:0]  s_tdata,
	// [1:0] func
	input  logic [1:0]              s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// [0] compressor_on, [16:1] on_seconds, [32:17] off_seconds,
	// [48:33] protect_remaining, [49] protect_expired, [50] over_first_limit,
	// [51] over_second_limit, [67:52] run_count, [71:68] zero
	output logic [OutDataWidth-1:0] m_tdata,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [AddrWidth-1:0]    paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t result;
	result_t result_q;
	logic    out_valid_q;

	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func          <= s_tuser;
			item_s1.cold_request  <= s_tdata[0];
			item_s1.ice_request   <= s_tdata[1];
			item_s1.forced_mode   <= s_tdata[2];
			item_s1.forced_on     <= s_tdata[3];
			item_s1.protect_value <= s_tdata[19:4];
		end
	end

	cpt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.en     (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, result_q};

endmodule
